// File: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int OP_W     = 3;
  localparam int VALUE_W  = 31;
  localparam int RESULT_W = 32;
  localparam int STAT_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5,
    OP_END  = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_UNDER = 3'd1,
    STAT_ZDIV  = 3'd2,
    STAT_LEFT  = 3'd3,
    STAT_OVER  = 3'd4,
    STAT_EMPTY = 3'd5
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RD_A = 3'd1,
    ST_LOAD = 3'd2,
    ST_CALC = 3'd3,
    ST_END  = 3'd4
  } state_t;

  typedef struct packed {
    logic start;
    logic is_mul;
    logic is_rem;
  } md_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rpn_muldiv.sv
// ----------------------------------------------------------------------------
// rpn_muldiv
// Iterative multiply (shift-add) and signed divide/remainder (restoring),
// one bit per cycle, WIDTH shift steps per operation.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_muldiv #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpn_pkg::md_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] b,
  output logic                  done,
  output logic      [WIDTH-1:0] result
);

  import rpn_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic             is_mul;
  logic             is_rem;
  logic             neg_q;
  logic             neg_r;

  logic [WIDTH-1:0] mag_a;
  logic [WIDTH-1:0] mag_b;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   diff;

  assign mag_a  = a[WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b  = b[WIDTH-1] ? (~b + 1'b1) : b;
  assign rem_sh = {acc, x[WIDTH-1]};
  assign diff   = rem_sh - {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      acc    <= '0;
      is_mul <= ctrl.is_mul;
      is_rem <= ctrl.is_rem;
      neg_q  <= a[WIDTH-1] ^ b[WIDTH-1];
      neg_r  <= a[WIDTH-1];
      if (ctrl.is_mul) begin
        x <= a;
        y <= b;
      end else begin
        x <= mag_a;
        y <= mag_b;
      end
    end else if (busy) begin
      if (is_mul) begin
        acc <= acc + (y[0] ? x : '0);
        x   <= {x[WIDTH-2:0], 1'b0};
        y   <= {1'b0, y[WIDTH-1:1]};
      end else if (!diff[WIDTH]) begin
        acc <= diff[WIDTH-1:0];
        x   <= {x[WIDTH-2:0], 1'b1};
      end else begin
        acc <= rem_sh[WIDTH-1:0];
        x   <= {x[WIDTH-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (is_mul) begin
      result = acc;
    end else if (is_rem) begin
      result = neg_r ? (~acc + 1'b1) : acc;
    end else begin
      result = neg_q ? (~x + 1'b1) : x;
    end
  end

endmodule

`default_nettype wire

// File: rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Postfix integer expression evaluator on a stack held in a synchronous RAM.
// ----------------------------------------------------------------------------
// push, and any token but end after an error, is handled in ST_IDLE alone
// add and sub pass through ST_RD_A and ST_LOAD: two stack reads through the one RAM read port
// mul, div and rem also wait in ST_CALC for the bit-serial muldiv unit, but not on a zero divisor
// end passes through ST_END to the output register, which frees the input side
// synchronous reset empties the stack and clears the error, no RAM clearing pass
`default_nettype none

module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [rpn_pkg::RESULT_W-1:0]    s_tdata,  // value[30:0], zero pad
  input  wire logic [rpn_pkg::OP_W-1:0]        s_tuser,  // op[2:0]
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [rpn_pkg::RESULT_W-1:0]    m_tdata,  // result[31:0]
  output logic      [rpn_pkg::STAT_W-1:0]      m_tuser   // status[2:0]
);

  import rpn_pkg::*;

  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
  localparam logic [SPW-1:0] SP_ONE  = SPW'(1);
  localparam logic [SPW-1:0] SP_TWO  = SPW'(2);

  state_t          state;
  state_t          state_next;
  logic [SPW-1:0]  sp;
  logic [SPW-1:0]  sp_next;
  stat_t           err;
  stat_t           err_next;
  stat_t           end_stat;
  stat_t           end_stat_next;
  op_t             op_r;
  logic [DATA_WIDTH-1:0] b_r;

  op_t             tok_op;
  logic [SPW-1:0]  sp_m1;
  logic [SPW-1:0]  sp_m2;
  logic [DATA_WIDTH-1:0] push_val;
  logic [RESULT_W-1:0]   top_ext;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  md_ctrl_t              md_ctrl;
  logic                  md_done;
  logic [DATA_WIDTH-1:0] md_result;
  logic                  out_load;

  assign tok_op = op_t'(s_tuser);
  assign sp_m1  = sp - SP_ONE;
  assign sp_m2  = sp - SP_TWO;

  generate
    if (DATA_WIDTH > VALUE_W) begin : g_push_wide
      assign push_val = {{(DATA_WIDTH - VALUE_W){1'b0}}, s_tdata[VALUE_W-1:0]};
    end else begin : g_push_narrow
      assign push_val = s_tdata[DATA_WIDTH-1:0];
    end
    if (DATA_WIDTH >= RESULT_W) begin : g_res_wide
      assign top_ext = rd_data[RESULT_W-1:0];
    end else begin : g_res_narrow
      assign top_ext = {{(RESULT_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
    end
  endgenerate

  rpn_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rpn_muldiv #(
    .WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (md_ctrl),
    .a      (rd_data),
    .b      (b_r),
    .done   (md_done),
    .result (md_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    sp_next        = sp;
    err_next       = err;
    end_stat_next  = end_stat;
    s_tready       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    md_ctrl        = '0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (tok_op == OP_END) begin
            sp_next    = '0;
            err_next   = STAT_OK;
            state_next = ST_END;
            if (err != STAT_OK) begin
              end_stat_next = err;
            end else if (sp == '0) begin
              end_stat_next = STAT_EMPTY;
            end else if (sp != SP_ONE) begin
              end_stat_next = STAT_LEFT;
            end else begin
              end_stat_next = STAT_OK;
              rd_en         = 1'b1;
              rd_addr       = '0;
            end
          end else if (err == STAT_OK) begin
            case (tok_op)
              OP_PUSH: begin
                if (sp == SP_FULL) begin
                  err_next = STAT_OVER;
                end else begin
                  wr_en   = 1'b1;
                  wr_addr = sp[AW-1:0];
                  wr_data = push_val;
                  sp_next = sp + SP_ONE;
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM: begin
                if (sp < SP_TWO) begin
                  err_next = STAT_UNDER;
                end else begin
                  rd_en      = 1'b1;
                  rd_addr    = sp_m1[AW-1:0];
                  state_next = ST_RD_A;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_RD_A: begin
        rd_en      = 1'b1;
        rd_addr    = sp_m2[AW-1:0];
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if ((op_r == OP_DIV || op_r == OP_REM) && b_r == '0) begin
          err_next   = STAT_ZDIV;
          state_next = ST_IDLE;
        end else if (op_r == OP_ADD || op_r == OP_SUB) begin
          wr_en      = 1'b1;
          wr_addr    = sp_m2[AW-1:0];
          wr_data    = (op_r == OP_ADD) ? (rd_data + b_r) : (rd_data - b_r);
          sp_next    = sp_m1;
          state_next = ST_IDLE;
        end else begin
          md_ctrl.start  = 1'b1;
          md_ctrl.is_mul = (op_r == OP_MUL);
          md_ctrl.is_rem = (op_r == OP_REM);
          state_next     = ST_CALC;
        end
      end
      ST_CALC: begin
        if (md_done) begin
          wr_en      = 1'b1;
          wr_addr    = sp_m2[AW-1:0];
          wr_data    = md_result;
          sp_next    = sp_m1;
          state_next = ST_IDLE;
        end
      end
      ST_END: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp       <= '0;
      err      <= STAT_OK;
      m_tvalid <= 1'b0;
    end else begin
      sp  <= sp_next;
      err <= err_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_stat <= end_stat_next;
    if (state == ST_IDLE && s_tvalid) begin
      op_r <= tok_op;
    end
    if (state == ST_RD_A) begin
      b_r <= rd_data;
    end
    if (out_load) begin
      m_tdata <= (end_stat == STAT_OK) ? top_ext : '0;
      m_tuser <= end_stat;
    end
  end

endmodule

`default_nettype wire
